### rtl/cfr_pkg.sv
// Shared types and constants of the chunked frame reassembler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cfr_pkg;

  localparam int CHUNK_BYTES = 1024;
  localparam int CHUNK_SHIFT = 10;
  localparam int MAX_CHUNKS = 4096;
  localparam int CHUNK_IDX_W = 12;
  localparam int MAP_ROW_W = 16;
  localparam int MAP_ROW_BITS = 4;
  localparam int MAP_ROWS = MAX_CHUNKS / MAP_ROW_W;
  localparam int MAP_ADDR_W = CHUNK_IDX_W - MAP_ROW_BITS;
  localparam logic [22:0] FRAME_MEM_BYTES = 23'd4194304;
  localparam logic [15:0] IDLE_EXPIRED = 16'hFFFF;
  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd200;

  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] CFG_MAGIC = 2'd0;
  localparam logic [1:0] CFG_MAX_BYTES = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] magic_word;
    logic [31:0] frame_number;
    logic [31:0] frame_total_bytes;
    logic [15:0] chunk_number;
    logic [15:0] chunks_in_frame;
    logic [15:0] chunk_payload_bytes;
    logic [15:0] body_bytes;
    logic [7:0]  payload_byte;
    logic        end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [21:0] write_address;
    logic [7:0]  write_data;
    logic [31:0] done_frame_number;
    logic [22:0] done_frame_bytes;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic                   hdr_pass;
    logic                   off_ok;
    logic [31:0]            frame_number;
    logic [22:0]            frame_bytes;
    logic [15:0]            chunk_total;
    logic [CHUNK_IDX_W-1:0] chunk_idx;
    logic [10:0]            payload_len;
    logic [7:0]             payload_byte;
    logic                   eop;
  } cmd_t;

  typedef struct packed {
    logic       push0;
    logic       push1;
    out_item_t  item0;
    out_item_t  item1;
  } res_push_t;

endpackage

### rtl/cfr_front.sv
// Front stage: configuration registers, input register and header checks.
// Depends on cfr_pkg.
`timescale 1ns / 1ps
module cfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  cfr_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output cfr_pkg::cmd_t     cmd,
  input  logic              cmd_take,
  output logic [15:0]       idle_timeout
);

  logic [31:0] magic_r;
  logic [22:0] max_bytes_r;
  logic [15:0] timeout_r;
  logic        valid_r;
  cfr_pkg::cmd_t cmd_r;
  cfr_pkg::cmd_t cmd_nxt;
  logic [22:0] limit;
  logic [26:0] end_off;
  logic        load;

  assign in_stall = valid_r && !cmd_take;
  assign load = in_valid && !in_stall;
  assign limit = (max_bytes_r > cfr_pkg::FRAME_MEM_BYTES) ? cfr_pkg::FRAME_MEM_BYTES
                                                          : max_bytes_r;
  assign end_off = {1'b0, in_data.chunk_number, 10'd0} + 27'(in_data.chunk_payload_bytes);

  always_comb begin
    cmd_nxt.opcode = in_data.opcode;
    cmd_nxt.hdr_pass = (in_data.magic_word == magic_r) &&
                       (in_data.frame_total_bytes != 32'd0) &&
                       (in_data.frame_total_bytes <= 32'(limit)) &&
                       (in_data.chunks_in_frame != 16'd0) &&
                       (in_data.chunk_number < in_data.chunks_in_frame) &&
                       (in_data.chunk_payload_bytes != 16'd0) &&
                       (in_data.chunk_payload_bytes <= 16'(cfr_pkg::CHUNK_BYTES)) &&
                       (in_data.chunk_payload_bytes <= in_data.body_bytes);
    cmd_nxt.off_ok = (32'(end_off) <= in_data.frame_total_bytes) &&
                     (in_data.chunk_number < 16'(cfr_pkg::MAX_CHUNKS));
    cmd_nxt.frame_number = in_data.frame_number;
    cmd_nxt.frame_bytes = in_data.frame_total_bytes[22:0];
    cmd_nxt.chunk_total = in_data.chunks_in_frame;
    cmd_nxt.chunk_idx = in_data.chunk_number[cfr_pkg::CHUNK_IDX_W-1:0];
    cmd_nxt.payload_len = in_data.chunk_payload_bytes[10:0];
    cmd_nxt.payload_byte = in_data.payload_byte;
    cmd_nxt.eop = in_data.end_of_packet;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= 32'd0;
      max_bytes_r <= cfr_pkg::FRAME_MEM_BYTES;
      timeout_r <= cfr_pkg::IDLE_TIMEOUT_RESET;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cfr_pkg::CFG_MAGIC:     magic_r <= cfg_wdata;
          cfr_pkg::CFG_MAX_BYTES: max_bytes_r <= cfg_wdata[22:0];
          cfr_pkg::CFG_TIMEOUT:   timeout_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (load) valid_r <= 1'b1;
      else if (cmd_take) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cmd_r <= cmd_nxt;
  end

  assign cmd_valid = valid_r;
  assign cmd = cmd_r;
  assign idle_timeout = timeout_r;

endmodule

### rtl/cfr_back.sv
// Back stage: assembly state, chunk map memory and result generation.
// Depends on cfr_pkg; fed by cfr_front, feeds cfr_res_fifo.
`timescale 1ns / 1ps
module cfr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  input  cfr_pkg::cmd_t                  cmd,
  output logic                           cmd_take,
  input  logic                           rd_en,
  input  logic [cfr_pkg::MAP_ADDR_W-1:0] rd_addr,
  input  logic [15:0]                    idle_timeout,
  input  logic                           fifo_room,
  output cfr_pkg::res_push_t             push
);

  localparam int RW = cfr_pkg::MAP_ROW_W;
  localparam int AW = cfr_pkg::MAP_ADDR_W;
  localparam int IW = cfr_pkg::CHUNK_IDX_W;

  logic [RW-1:0] map_mem [cfr_pkg::MAP_ROWS];
  logic [RW-1:0] rdata_r;
  logic [cfr_pkg::MAP_ROWS-1:0] row_valid_r, row_valid_nxt;
  logic          asm_r, asm_nxt;
  logic [31:0]   fnum_r, fnum_nxt;
  logic [22:0]   fbytes_r, fbytes_nxt;
  logic [15:0]   ctot_r, ctot_nxt;
  logic [12:0]   crcv_r, crcv_nxt;
  logic [15:0]   idle_r, idle_nxt;
  logic          cacc_r, cacc_nxt;
  logic [IW-1:0] achunk_r, achunk_nxt;
  logic [21:0]   wad_r, wad_nxt;
  logic [10:0]   left_r, left_nxt;
  logic [RW-1:0] arow_r, arow_nxt;
  logic          mwe;
  logic [AW-1:0] mwaddr;
  logic [RW-1:0] mwdata;
  logic          fire, restart, seen;
  logic [RW-1:0] row_now;
  logic [15:0]   idle_inc;

  assign fire = cmd_valid && fifo_room;
  assign cmd_take = fire;

  always_comb begin
    asm_nxt = asm_r;
    fnum_nxt = fnum_r;
    fbytes_nxt = fbytes_r;
    ctot_nxt = ctot_r;
    crcv_nxt = crcv_r;
    idle_nxt = idle_r;
    cacc_nxt = cacc_r;
    achunk_nxt = achunk_r;
    wad_nxt = wad_r;
    left_nxt = left_r;
    arow_nxt = arow_r;
    row_valid_nxt = row_valid_r;
    mwe = 1'b0;
    mwaddr = achunk_r[IW-1:cfr_pkg::MAP_ROW_BITS];
    mwdata = arow_r | (RW'(1) << achunk_r[cfr_pkg::MAP_ROW_BITS-1:0]);
    push = '0;
    restart = 1'b0;
    seen = 1'b0;
    row_now = '0;
    idle_inc = (idle_r < cfr_pkg::IDLE_EXPIRED) ? idle_r + 16'd1 : idle_r;
    if (fire) begin
      unique case (cmd.opcode)
        cfr_pkg::OP_HEADER: begin
          cacc_nxt = 1'b0;
          left_nxt = '0;
          if (cmd.hdr_pass) begin
            restart = !asm_r || (cmd.frame_number != fnum_r) ||
                      (cmd.frame_bytes != fbytes_r) || (cmd.chunk_total != ctot_r);
            if (restart) begin
              crcv_nxt = '0;
              row_valid_nxt = '0;
              idle_nxt = cfr_pkg::IDLE_EXPIRED;
              fnum_nxt = cmd.frame_number;
              fbytes_nxt = cmd.frame_bytes;
              ctot_nxt = cmd.chunk_total;
              asm_nxt = 1'b1;
            end
            if (!restart && row_valid_r[cmd.chunk_idx[IW-1:cfr_pkg::MAP_ROW_BITS]]) begin
              row_now = rdata_r;
            end
            seen = row_now[cmd.chunk_idx[cfr_pkg::MAP_ROW_BITS-1:0]];
            if (cmd.off_ok && !seen) begin
              cacc_nxt = 1'b1;
              achunk_nxt = cmd.chunk_idx;
              wad_nxt = {cmd.chunk_idx, 10'd0};
              left_nxt = cmd.payload_len;
              idle_nxt = 16'd0;
              arow_nxt = row_now;
            end
          end
        end
        cfr_pkg::OP_TICK: begin
          idle_nxt = idle_inc;
          if (asm_r && (idle_inc > idle_timeout)) begin
            asm_nxt = 1'b0;
            fnum_nxt = '0;
            fbytes_nxt = '0;
            ctot_nxt = '0;
            crcv_nxt = '0;
            row_valid_nxt = '0;
            idle_nxt = cfr_pkg::IDLE_EXPIRED;
            cacc_nxt = 1'b0;
            left_nxt = '0;
          end
        end
        cfr_pkg::OP_PAYLOAD: begin
          if (cacc_r && (left_r != '0)) begin
            push.push0 = 1'b1;
            push.item0.result_kind = cfr_pkg::KIND_WRITE;
            push.item0.write_address = wad_r;
            push.item0.write_data = cmd.payload_byte;
            push.item0.last_result = 1'b1;
            wad_nxt = wad_r + 22'd1;
            left_nxt = left_r - 11'd1;
          end
          if (cmd.eop && cacc_r) begin
            cacc_nxt = 1'b0;
            left_nxt = '0;
            if (!arow_r[achunk_r[cfr_pkg::MAP_ROW_BITS-1:0]]) begin
              mwe = 1'b1;
              row_valid_nxt[mwaddr] = 1'b1;
              crcv_nxt = crcv_r + 13'd1;
            end
            if (asm_r && ({3'd0, crcv_nxt} == ctot_r)) begin
              asm_nxt = 1'b0;
              if (push.push0) begin
                push.item0.last_result = 1'b0;
                push.push1 = 1'b1;
                push.item1.result_kind = cfr_pkg::KIND_DONE;
                push.item1.done_frame_number = fnum_r;
                push.item1.done_frame_bytes = fbytes_r;
                push.item1.last_result = 1'b1;
              end else begin
                push.push0 = 1'b1;
                push.item0.result_kind = cfr_pkg::KIND_DONE;
                push.item0.done_frame_number = fnum_r;
                push.item0.done_frame_bytes = fbytes_r;
                push.item0.last_result = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) map_mem[mwaddr] <= mwdata;
    if (rd_en) rdata_r <= (mwe && (mwaddr == rd_addr)) ? mwdata : map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r <= 1'b0;
      fnum_r <= '0;
      fbytes_r <= '0;
      ctot_r <= '0;
      crcv_r <= '0;
      idle_r <= '0;
      cacc_r <= 1'b0;
      achunk_r <= '0;
      wad_r <= '0;
      left_r <= '0;
      arow_r <= '0;
      row_valid_r <= '0;
    end else begin
      asm_r <= asm_nxt;
      fnum_r <= fnum_nxt;
      fbytes_r <= fbytes_nxt;
      ctot_r <= ctot_nxt;
      crcv_r <= crcv_nxt;
      idle_r <= idle_nxt;
      cacc_r <= cacc_nxt;
      achunk_r <= achunk_nxt;
      wad_r <= wad_nxt;
      left_r <= left_nxt;
      arow_r <= arow_nxt;
      row_valid_r <= row_valid_nxt;
    end
  end

  a_left_needs_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != '0) |-> cacc_r) else $error("bytes pending without an accepted chunk");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    crcv_r <= 13'(cfr_pkg::MAX_CHUNKS)) else $error("chunk count beyond map size");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.push0 || push.push1) |-> fifo_room) else $error("results pushed without room");
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0) else $error("second result without first");

endmodule

### rtl/cfr_res_fifo.sv
// Result queue: four entries, up to two pushes and one pop a cycle.
// Depends on cfr_pkg; filled by cfr_back.
`timescale 1ns / 1ps
module cfr_res_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  cfr_pkg::res_push_t  push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output cfr_pkg::out_item_t  out_data
);

  cfr_pkg::out_item_t mem_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic [1:0] npush;

  assign pop = out_valid && !out_stall;
  assign out_valid = cnt_r != 3'd0;
  assign out_data = mem_r[rd_r];
  assign room = cnt_r <= 3'd2;
  assign npush = {1'b0, push.push0} + {1'b0, push.push1};

  always_ff @(posedge clk) begin
    if (push.push0) mem_r[wr_r] <= push.item0;
    if (push.push1) mem_r[wr_r + 2'd1] <= push.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
      wr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_r + npush;
      if (pop) rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, npush} - {2'b0, pop};
    end
  end

endmodule

### rtl/chunked_frame_reassembler_top.sv
// Top level of the chunked frame reassembler.
// Depends on cfr_pkg, cfr_front, cfr_back and cfr_res_fifo.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data (in_item_t)
//   out      output     out_valid/out_stall  out_data (out_item_t)
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One item is taken every cycle while in_stall is low; a header is registered before its map decision.
// The chunk map is 256 rows of 16 bits with a valid flip-flop per row, so no clearing pass.
// Reset is synchronous; a result is registered in the result queue when its request is taken.
// An item waits in the front register while the four-entry result queue is nearly full.
`timescale 1ns / 1ps
module chunked_frame_reassembler_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cfr_pkg::out_item_t out_data
);

  logic               cmd_valid, cmd_take, room;
  cfr_pkg::cmd_t      cmd;
  cfr_pkg::res_push_t push;
  logic [15:0]        idle_timeout;

  cfr_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .idle_timeout(idle_timeout)
  );

  cfr_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .rd_en(in_valid && !in_stall),
    .rd_addr(in_data.chunk_number[cfr_pkg::CHUNK_IDX_W-1:cfr_pkg::MAP_ROW_BITS]),
    .idle_timeout(idle_timeout), .fifo_room(room), .push(push)
  );

  cfr_res_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .room(room),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

### verif/chunked_frame_reassembler_top_tb.sv
// Self-checking testbench for the chunked frame reassembler top level.
// Depends on cfr_pkg and chunked_frame_reassembler_top; predicts writes and completions.
`timescale 1ns / 1ps
module chunked_frame_reassembler_top_tb;

  localparam int IN_W = $bits(cfr_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  cfr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cfr_pkg::out_item_t out_data;

  chunked_frame_reassembler_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  cfr_pkg::in_item_t pending_q[$];
  cfr_pkg::out_item_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  int stall_mode = 0;

  logic [31:0] magic_r;
  logic [22:0] maxb_r;
  logic [15:0] tmo_r;
  logic asm_f;
  logic [31:0] cur_fnum;
  logic [22:0] cur_bytes;
  logic [15:0] cur_total;
  logic [12:0] chunks_got;
  logic seen_map [cfr_pkg::MAX_CHUNKS];
  logic [15:0] idle_cnt;
  logic chunk_live;
  logic [11:0] live_chunk;
  logic [21:0] wr_addr;
  logic [10:0] left_cnt;

  logic [31:0] cur_magic;

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  task automatic abandon_frame();
    asm_f = 0; cur_fnum = 0; cur_bytes = 0; cur_total = 0; chunks_got = 0;
    foreach (seen_map[i]) seen_map[i] = 0;
    idle_cnt = cfr_pkg::IDLE_EXPIRED; chunk_live = 0; live_chunk = 0; wr_addr = 0;
    left_cnt = 0;
  endtask

  task automatic reset_reassembly();
    magic_r = 0; maxb_r = cfr_pkg::FRAME_MEM_BYTES; tmo_r = cfr_pkg::IDLE_TIMEOUT_RESET;
    abandon_frame();
    idle_cnt = 0;
  endtask

  task automatic predict_item(input cfr_pkg::in_item_t it);
    logic [22:0] lim;
    logic [63:0] off;
    cfr_pkg::out_item_t r;
    int n;
    n = 0;
    r = '0;
    lim = (maxb_r > cfr_pkg::FRAME_MEM_BYTES) ? cfr_pkg::FRAME_MEM_BYTES : maxb_r;
    if (it.opcode == cfr_pkg::OP_HEADER) begin
      chunk_live = 0; left_cnt = 0;
      if (it.magic_word == magic_r && it.frame_total_bytes != 0 &&
          it.frame_total_bytes <= lim && it.chunks_in_frame != 0 &&
          it.chunk_number < it.chunks_in_frame && it.chunk_payload_bytes != 0 &&
          it.chunk_payload_bytes <= cfr_pkg::CHUNK_BYTES &&
          it.chunk_payload_bytes <= it.body_bytes) begin
        if (!asm_f || it.frame_number != cur_fnum ||
            it.frame_total_bytes != cur_bytes || it.chunks_in_frame != cur_total) begin
          abandon_frame();
          cur_fnum = it.frame_number; cur_bytes = it.frame_total_bytes[22:0];
          cur_total = it.chunks_in_frame; asm_f = 1;
        end
        off = 64'(it.chunk_number) * cfr_pkg::CHUNK_BYTES;
        if (off + it.chunk_payload_bytes <= it.frame_total_bytes &&
            it.chunk_number < cfr_pkg::MAX_CHUNKS && !seen_map[it.chunk_number]) begin
          chunk_live = 1; live_chunk = it.chunk_number[11:0];
          wr_addr = off[21:0]; left_cnt = it.chunk_payload_bytes[10:0]; idle_cnt = 0;
        end
      end
    end else if (it.opcode == cfr_pkg::OP_TICK) begin
      if (idle_cnt != cfr_pkg::IDLE_EXPIRED) idle_cnt++;
      if (asm_f && idle_cnt > tmo_r) abandon_frame();
    end else if (it.opcode == cfr_pkg::OP_PAYLOAD) begin
      if (chunk_live && left_cnt > 0) begin
        r = '0; r.result_kind = cfr_pkg::KIND_WRITE; r.write_address = wr_addr;
        r.write_data = it.payload_byte;
        expected_q.push_back(r); n++;
        wr_addr++; left_cnt--;
      end
      if (it.end_of_packet && chunk_live) begin
        chunk_live = 0; left_cnt = 0;
        if (!seen_map[live_chunk]) begin
          seen_map[live_chunk] = 1; chunks_got++;
        end
        if (asm_f && 16'(chunks_got) == cur_total) begin
          r = '0; r.result_kind = cfr_pkg::KIND_DONE; r.done_frame_number = cur_fnum;
          r.done_frame_bytes = cur_bytes;
          expected_q.push_back(r); n++;
          asm_f = 0;
        end
      end
    end
    if (n > 0) expected_q[$].last_result = 1'b1;
  endtask

  function automatic cfr_pkg::in_item_t rand_noise();
    cfr_pkg::in_item_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic cfr_pkg::in_item_t make_header(input logic [31:0] fn,
      input logic [31:0] total, input logic [15:0] idx, input logic [15:0] cnt,
      input logic [15:0] psz, input logic [15:0] body);
    cfr_pkg::in_item_t it;
    it = rand_noise();
    it.opcode = cfr_pkg::OP_HEADER; it.magic_word = cur_magic; it.frame_number = fn;
    it.frame_total_bytes = total; it.chunk_number = idx; it.chunks_in_frame = cnt;
    it.chunk_payload_bytes = psz; it.body_bytes = body;
    return it;
  endfunction

  function automatic cfr_pkg::in_item_t make_byte(input logic eop);
    cfr_pkg::in_item_t it;
    it = rand_noise();
    it.opcode = cfr_pkg::OP_PAYLOAD; it.end_of_packet = eop;
    return it;
  endfunction

  function automatic cfr_pkg::in_item_t make_tick();
    cfr_pkg::in_item_t it;
    it = rand_noise();
    it.opcode = cfr_pkg::OP_TICK;
    return it;
  endfunction

  task automatic queue_packet(input logic [31:0] fn, input logic [31:0] total,
      input int idx, input int cnt, input int psz, input int body);
    pending_q.push_back(make_header(fn, total, idx[15:0], cnt[15:0], psz[15:0], body[15:0]));
    for (int i = 0; i < body; i++) pending_q.push_back(make_byte(i == body - 1));
  endtask

  task automatic queue_frame(input int nch, input int last_len);
    logic [31:0] fn;
    int total;
    int order[$];
    int len;
    fn = $urandom;
    total = (nch - 1) * cfr_pkg::CHUNK_BYTES + last_len;
    for (int i = 0; i < nch; i++) order.push_back(i);
    order.shuffle();
    foreach (order[k]) begin
      len = (order[k] == nch - 1) ? last_len : cfr_pkg::CHUNK_BYTES;
      if (len > 12 && order[k] != nch - 1) len = $urandom_range(1, 12);
      queue_packet(fn, total, order[k], nch, len,
                   (order[k] == nch - 1) ? last_len + $urandom_range(0, 2) : len);
      if ($urandom_range(0, 5) == 0) pending_q.push_back(make_tick());
    end
  endtask

  task automatic run_phase();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cfr_pkg::CFG_MAGIC) magic_r = val;
    else if (idx == cfr_pkg::CFG_MAX_BYTES) maxb_r = val[22:0];
    else tmo_r = val[15:0];
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[chunked_frame_reassembler_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_item(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && gap_left == 0) begin
          in_valid <= 1'b1;
          in_data <= pending_q.pop_front();
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) report("unexpected result", out_data, 0);
        else begin
          cfr_pkg::out_item_t e;
          e = expected_q.pop_front();
          if (out_data.result_kind !== e.result_kind)
            report("result_kind", out_data.result_kind, e.result_kind);
          if (out_data.write_address !== e.write_address)
            report("write_address", out_data.write_address, e.write_address);
          if (out_data.write_data !== e.write_data)
            report("write_data", out_data.write_data, e.write_data);
          if (out_data.done_frame_number !== e.done_frame_number)
            report("done_frame_number", out_data.done_frame_number, e.done_frame_number);
          if (out_data.done_frame_bytes !== e.done_frame_bytes)
            report("done_frame_bytes", out_data.done_frame_bytes, e.done_frame_bytes);
          if (out_data.last_result !== e.last_result)
            report("last_result", out_data.last_result, e.last_result);
        end
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= (stall_phase % 7) < 3;
        default: out_stall <= ($urandom_range(0, 3) == 0);
      endcase
      if (stall_phase % 500 == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  initial begin
    int sel;
    cfr_pkg::in_item_t it;
    reset_reassembly();
    cur_magic = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset settings.
    queue_packet(32'h1, 5, 0, 1, 5, 5);
    pending_q.push_back(make_header(32'h2, 0, 0, 1, 1, 1));
    pending_q.push_back(make_header(32'h2, 32'hFFFFFFFF, 0, 1, 1, 1));
    pending_q.push_back(make_header(32'h2, 100, 1, 1, 1, 1));
    pending_q.push_back(make_header(32'h2, 100, 0, 0, 1, 1));
    pending_q.push_back(make_header(32'h2, 2000, 0, 2, 1025, 1025));
    pending_q.push_back(make_header(32'h2, 2000, 0, 2, 4, 3));
    queue_packet(32'h3, 2000, 1, 2, 1000, 3);
    queue_packet(32'h3, 2000, 1, 2, 2, 4);
    queue_packet(32'h3, 2000, 1, 2, 2, 2);
    pending_q.push_back(make_byte(1));
    it = make_tick(); pending_q.push_back(it);
    it = rand_noise(); it.opcode = cfr_pkg::OP_UNUSED; pending_q.push_back(it);
    queue_packet(32'hFFFFFFFF, 4194304, 16'hFFFF, 16'hFFFF, 1024, 1);
    run_phase();

    write_reg(cfr_pkg::CFG_MAGIC, 32'hFFFFFFFF); cur_magic = 32'hFFFFFFFF;
    write_reg(cfr_pkg::CFG_MAX_BYTES, 32'h007FFFFF);
    write_reg(cfr_pkg::CFG_TIMEOUT, 32'd1);
    queue_frame(2, 1); repeat (3) pending_q.push_back(make_tick());
    queue_packet(32'h9, 3000, 0, 3, 3, 3);
    queue_frame(1, 1024);
    run_phase();

    for (int ph = 0; ph < 4; ph++) begin
      cur_magic = $urandom;
      write_reg(cfr_pkg::CFG_MAGIC, cur_magic);
      write_reg(cfr_pkg::CFG_MAX_BYTES,
                (ph == 0) ? 1 : (ph == 1) ? 4194304 : $urandom_range(2000, 9000));
      write_reg(cfr_pkg::CFG_TIMEOUT,
                (ph == 0) ? 65534 : (ph == 1) ? 1 : $urandom_range(2, 40));
      while (pending_q.size() < 60) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) queue_frame($urandom_range(1, 3), $urandom_range(1, 40));
        else if (sel < 7) begin
          it = rand_noise(); if ($urandom_range(0, 1)) it.magic_word = cur_magic;
          pending_q.push_back(it);
        end else if (sel < 8) pending_q.push_back(make_tick());
        else queue_packet($urandom_range(0, 3), $urandom_range(1, 3000),
                          $urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 30), $urandom_range(0, 30));
      end
      run_phase();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("[chunked_frame_reassembler_top] OK");
    end else begin
      $display("[chunked_frame_reassembler_top] ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/cfr_pkg.sv
rtl/cfr_front.sv
rtl/cfr_back.sv
rtl/cfr_res_fifo.sv
rtl/chunked_frame_reassembler_top.sv
verif/chunked_frame_reassembler_top_tb.sv
